[hw/rtl/pixel_upscale_background_composite_assert.svh]
// assertion macros for the pixel upscale checker
// expects signals named clk and rst_n in the scope of each use
`ifndef PIXEL_UPSCALE_BACKGROUND_COMPOSITE_ASSERT_SVH
`define PIXEL_UPSCALE_BACKGROUND_COMPOSITE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PUBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PUBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pubc_pkg.sv]
// shared types and constants for the pixel upscale / background composite block
// no dependencies
package pubc_pkg;

  localparam int MAX_CANVAS_WIDTH_DEF = 1024;
  localparam int MAX_SCALE_DEF        = 64;
  localparam int HEIGHT_LIMIT         = 1024;
  localparam int ROW_W                = 10;
  localparam int CFG_W                = 11;
  localparam int CFG_IDX_W            = 3;
  localparam int ACC_W                = 16;

  localparam logic [7:0] CH_MAX   = 8'd255;
  localparam logic [7:0] ROUND_C  = 8'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_FACTOR    = 3'd0,
    REG_BACKGROUND_MODE = 3'd1,
    REG_CANVAS_WIDTH    = 3'd2,
    REG_CANVAS_HEIGHT   = 3'd3,
    REG_BUFFER_WIDTH    = 3'd4,
    REG_BUFFER_HEIGHT   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    BG_TRANSPARENT = 2'd0,
    BG_BLACK       = 2'd1,
    BG_WHITE       = 2'd2,
    BG_ALT_BLACK   = 2'd3
  } bg_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_READ,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  // packed so that red sits in bits 7..0 and alpha in 31..24
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

endpackage

[hw/rtl/pubc_ram.sv]
// generic single-port ram with registered read
// no dependencies
module pubc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/pubc_blend.sv]
// shared composite unit: multiply-accumulate stage, then divide by 255
// depends on pubc_pkg
module pubc_blend (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] s,
  input  logic [7:0] a,
  input  logic       white,
  output logic [7:0] q
);

  logic [pubc_pkg::ACC_W-1:0] acc_r;
  logic [pubc_pkg::ACC_W-1:0] acc_nxt;
  logic [7:0]                 inv_a;
  logic [pubc_pkg::ACC_W-1:0] bg_term;
  logic [24:0]                scaled;
  logic [7:0]                 est;
  logic [pubc_pkg::ACC_W-1:0] rem;

  // s*a + bg*(255-a) + 127, bg is 0 or 255
  always_comb begin
    inv_a   = pubc_pkg::CH_MAX - a;
    bg_term = white ? ({inv_a, 8'd0} - {8'd0, inv_a}) : '0;
    acc_nxt = ({8'd0, s} * {8'd0, a}) + bg_term + {8'd0, pubc_pkg::ROUND_C};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  // x*257 >> 16 is the quotient or one short of it
  always_comb begin
    scaled = {1'b0, acc_r, 8'd0} + {9'd0, acc_r};
    est    = scaled[23:16];
    rem    = acc_r - {est, 8'd0} + {8'd0, est};
    q      = (rem >= {8'd0, pubc_pkg::CH_MAX}) ? est + 8'd1 : est;
  end

endmodule

[hw/rtl/pixel_upscale_background_composite.sv]
// top level of the nearest-neighbor upscaler with background composite
// depends on pubc_pkg, pubc_ram, pubc_blend
//
// Source BGRA pixels come in canvas row order and leave as RGBA, each one
// repeated scale times horizontally (one word per cycle while out_stall is
// low, last_of_run on the final copy). Each source row is sent once as op-0
// words, followed by canvas_width*(scale-1) op-1 replay words that re-emit
// the line store to repeat the row vertically. One word is handled at a time:
// a transparent or outside pixel goes straight to its copies, a replay first
// reads the line store in S_READ, a composited pixel runs multiply then
// divide-by-255 for each of red, green and blue through one shared unit, and
// after the last copy the block returns to idle, where the next word is taken.
// The line store has no reset: replaying a column never written since reset
// gives undefined data. Configuration is to be written only while idle; the
// block itself does not enforce this.
module pixel_upscale_background_composite #(
  parameter int MAX_CANVAS_WIDTH = pubc_pkg::MAX_CANVAS_WIDTH_DEF,
  parameter int MAX_SCALE        = pubc_pkg::MAX_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [pubc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pubc_pkg::CFG_W-1:0]     cfg_data,
  // input word
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [7:0]                     in_src_blue,
  input  logic [7:0]                     in_src_green,
  input  logic [7:0]                     in_src_red,
  input  logic [7:0]                     in_src_alpha,
  // output word
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  output logic                           out_last_of_run,
  output logic                           out_end_of_frame
);

  localparam int COL_W = (MAX_CANVAS_WIDTH > 1) ? $clog2(MAX_CANVAS_WIDTH) : 1;
  localparam int CW_W  = $clog2(MAX_CANVAS_WIDTH + 1) + 1;
  localparam int REP_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int SCL_W = $clog2(MAX_SCALE + 1) + 1;
  localparam int HT_W  = pubc_pkg::ROW_W + 1;

  // configuration registers
  logic [6:0]                 scale_factor_r;
  pubc_pkg::bg_mode_t         bg_mode_r;
  logic [pubc_pkg::CFG_W-1:0] canvas_width_r;
  logic [pubc_pkg::CFG_W-1:0] canvas_height_r;
  logic [pubc_pkg::CFG_W-1:0] buffer_width_r;
  logic [pubc_pkg::CFG_W-1:0] buffer_height_r;

  // position counters
  logic [COL_W-1:0]           col_r;
  logic [pubc_pkg::ROW_W-1:0] row_r;
  logic [REP_W-1:0]           rep_r;

  // per-word state
  pubc_pkg::state_t state_r, state_nxt;
  pubc_pkg::chan_t  ch_r, ch_nxt;
  pubc_pkg::pixel_t src_r, src_nxt;
  pubc_pkg::pixel_t pix_r, pix_nxt;
  logic [COL_W-1:0] addr_r;
  logic [SCL_W-1:0] cnt_r, cnt_nxt;
  logic             frame_end_r;

  // derived values
  logic [SCL_W-1:0] scale;
  logic [CW_W-1:0]  width;
  logic [HT_W-1:0]  height;
  logic             composite;
  logic             white;
  logic [7:0]       bg;
  logic             buf_hit;
  logic             row_end;
  logic             pass_end;
  logic             frame_end;
  logic             in_take;
  logic             out_take;
  logic             copy_last;
  pubc_pkg::pixel_t in_pix;
  pubc_pkg::pixel_t direct_pix;

  // ram and shared unit hookup
  logic             ram_we;
  logic [COL_W-1:0] ram_addr;
  pubc_pkg::pixel_t ram_wdata;
  logic [31:0]      ram_rdata;
  logic             blend_en;
  logic [7:0]       blend_s;
  logic [7:0]       blend_q;

  // clamped registers
  always_comb begin
    if (scale_factor_r > 7'(MAX_SCALE)) begin
      scale = SCL_W'(MAX_SCALE);
    end else if (scale_factor_r == 7'd0) begin
      scale = SCL_W'(1);
    end else begin
      scale = SCL_W'(scale_factor_r);
    end
    if (canvas_width_r > MAX_CANVAS_WIDTH) begin
      width = CW_W'(MAX_CANVAS_WIDTH);
    end else if (canvas_width_r == '0) begin
      width = CW_W'(1);
    end else begin
      width = CW_W'(canvas_width_r);
    end
    if (canvas_height_r > pubc_pkg::HEIGHT_LIMIT) begin
      height = HT_W'(pubc_pkg::HEIGHT_LIMIT);
    end else if (canvas_height_r == '0) begin
      height = HT_W'(1);
    end else begin
      height = HT_W'(canvas_height_r);
    end
  end

  assign composite = (bg_mode_r != pubc_pkg::BG_TRANSPARENT);
  assign white     = (bg_mode_r == pubc_pkg::BG_WHITE);
  assign bg        = white ? pubc_pkg::CH_MAX : 8'd0;

  assign buf_hit = (col_r < buffer_width_r) && (row_r < buffer_height_r) &&
                   (col_r < width) && (row_r < height);

  // end-of-row / pass / frame flags for the word being taken
  assign row_end   = ((CW_W'(col_r) + CW_W'(1)) >= width);
  assign pass_end  = row_end && ((SCL_W'(rep_r) + SCL_W'(1)) >= scale);
  assign frame_end = pass_end && ((HT_W'(row_r) + HT_W'(1)) >= height);

  assign in_stall = (state_r != pubc_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;

  assign in_pix = '{alpha: in_src_alpha, blue: in_src_blue,
                    green: in_src_green, red: in_src_red};

  // pixels that need no arithmetic
  always_comb begin
    if (!composite) begin
      direct_pix = buf_hit ? in_pix : '0;
    end else begin
      direct_pix = '{alpha: pubc_pkg::CH_MAX, blue: bg, green: bg, red: bg};
    end
  end

  assign copy_last = ((cnt_r + SCL_W'(1)) == scale);
  assign out_take  = out_valid && !out_stall;

  // select the channel fed to the shared unit
  always_comb begin
    case (ch_r)
      pubc_pkg::CH_RED:   blend_s = src_r.red;
      pubc_pkg::CH_GREEN: blend_s = src_r.green;
      pubc_pkg::CH_BLUE:  blend_s = src_r.blue;
      default:            blend_s = src_r.red;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    src_nxt   = src_r;
    pix_nxt   = pix_r;
    cnt_nxt   = cnt_r;
    ram_we    = 1'b0;
    ram_addr  = addr_r;
    ram_wdata = pix_r;
    blend_en  = 1'b0;
    case (state_r)
      pubc_pkg::S_IDLE: begin
        ram_addr = col_r;
        cnt_nxt  = '0;
        if (in_take) begin
          if (in_op) begin
            // replay: read the stored column
            state_nxt = pubc_pkg::S_READ;
          end else if (composite && buf_hit) begin
            src_nxt   = in_pix;
            ch_nxt    = pubc_pkg::CH_RED;
            state_nxt = pubc_pkg::S_MUL;
          end else begin
            pix_nxt   = direct_pix;
            ram_we    = 1'b1;
            ram_wdata = direct_pix;
            state_nxt = pubc_pkg::S_EMIT;
          end
        end
      end
      pubc_pkg::S_MUL: begin
        blend_en  = 1'b1;
        state_nxt = pubc_pkg::S_DIV;
      end
      pubc_pkg::S_DIV: begin
        case (ch_r)
          pubc_pkg::CH_RED: begin
            pix_nxt.red = blend_q;
            ch_nxt      = pubc_pkg::CH_GREEN;
            state_nxt   = pubc_pkg::S_MUL;
          end
          pubc_pkg::CH_GREEN: begin
            pix_nxt.green = blend_q;
            ch_nxt        = pubc_pkg::CH_BLUE;
            state_nxt     = pubc_pkg::S_MUL;
          end
          default: begin
            // blue is the last channel: pixel complete
            pix_nxt.blue  = blend_q;
            pix_nxt.alpha = pubc_pkg::CH_MAX;
            ram_we        = 1'b1;
            ram_wdata     = pix_nxt;
            state_nxt     = pubc_pkg::S_EMIT;
          end
        endcase
      end
      pubc_pkg::S_READ: begin
        pix_nxt   = pubc_pkg::pixel_t'(ram_rdata);
        state_nxt = pubc_pkg::S_EMIT;
      end
      pubc_pkg::S_EMIT: begin
        if (out_take) begin
          if (copy_last) begin
            cnt_nxt   = '0;
            state_nxt = pubc_pkg::S_IDLE;
          end else begin
            cnt_nxt = cnt_r + SCL_W'(1);
          end
        end
      end
      default: begin
        state_nxt = pubc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pubc_pkg::S_IDLE;
      ch_r    <= pubc_pkg::CH_RED;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    pix_r <= pix_nxt;
    if (in_take) begin
      addr_r      <= col_r;
      frame_end_r <= frame_end;
    end
  end

  // position counters advance on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      rep_r <= '0;
    end else if (in_take) begin
      if (row_end) begin
        col_r <= '0;
        if (pass_end) begin
          rep_r <= '0;
          row_r <= frame_end ? '0 : row_r + pubc_pkg::ROW_W'(1);
        end else begin
          rep_r <= rep_r + REP_W'(1);
        end
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_factor_r  <= 7'd1;
      bg_mode_r       <= pubc_pkg::BG_TRANSPARENT;
      canvas_width_r  <= pubc_pkg::CFG_W'(1);
      canvas_height_r <= pubc_pkg::CFG_W'(1);
      buffer_width_r  <= '0;
      buffer_height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pubc_pkg::REG_SCALE_FACTOR:    scale_factor_r  <= cfg_data[6:0];
        pubc_pkg::REG_BACKGROUND_MODE: bg_mode_r       <= pubc_pkg::bg_mode_t'(cfg_data[1:0]);
        pubc_pkg::REG_CANVAS_WIDTH:    canvas_width_r  <= cfg_data;
        pubc_pkg::REG_CANVAS_HEIGHT:   canvas_height_r <= cfg_data;
        pubc_pkg::REG_BUFFER_WIDTH:    buffer_width_r  <= cfg_data;
        pubc_pkg::REG_BUFFER_HEIGHT:   buffer_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // line store, one pixel per canvas column
  pubc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_CANVAS_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // shared multiply and divide-by-255 unit
  pubc_blend u_blend (
    .clk   (clk),
    .en    (blend_en),
    .s     (blend_s),
    .a     (src_r.alpha),
    .white (white),
    .q     (blend_q)
  );

  // output word straight from the held pixel and copy counter
  assign out_valid        = (state_r == pubc_pkg::S_EMIT);
  assign out_red          = pix_r.red;
  assign out_green        = pix_r.green;
  assign out_blue         = pix_r.blue;
  assign out_alpha        = pix_r.alpha;
  assign out_last_of_run  = copy_last;
  assign out_end_of_frame = copy_last && frame_end_r;

endmodule

[hw/rtl/pubc_checker.sv]
// port-level checks on the pixel upscale block, bound to the top level
// depends on pixel_upscale_background_composite_assert.svh
`include "pixel_upscale_background_composite_assert.svh"

module pubc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic       out_last_of_run,
  input logic       out_end_of_frame
);

  // a stalled output word holds
  `PUBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_red), "output word changed while stalled")

  // one word at a time: busy right after an accept
  `PUBC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken while previous word still in work")

  // no new input while copies are going out
  `PUBC_ASSERT_NOW(a_stall_while_emit, out_valid, in_stall, "input open while copies pending")

  // copies of a run follow without a gap
  `PUBC_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !out_last_of_run, out_valid, "run of copies broken")

  // end of frame only on the last copy
  `PUBC_ASSERT_NOW(a_eof_on_last, out_valid && out_end_of_frame, out_last_of_run, "end of frame not on last copy")

endmodule

bind pixel_upscale_background_composite pubc_checker u_pubc_checker (.*);

[dv/testbench.sv]
// self-checking testbench for pixel_upscale_background_composite
// depends on pubc_pkg and the block's rtl; a built-in predictor models every output word
// stimulus: a directed table first, then random frames under three idle/stall profiles
`timescale 1ns / 100ps

module testbench;

  // source op of an input word
  typedef enum logic {
    OP_PIXEL  = 1'b0,
    OP_REPLAY = 1'b1
  } op_t;

  // kind of a row in the directed table
  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } row_kind_t;

  // one predicted output word: the pixel plus its two marker bits
  typedef struct packed {
    pubc_pkg::pixel_t px;
    logic             last_of_run;
    logic             end_of_frame;
  } copy_t;

  // directed table row; want is used only when typed is set
  typedef struct {
    row_kind_t          kind;
    pubc_pkg::reg_idx_t idx;
    logic [10:0]        value;
    op_t                op;
    pubc_pkg::pixel_t   src;
    logic               typed;
    pubc_pkg::pixel_t   want;
  } dir_row_t;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int SETTLE_CYCLES  = 8;     // return to idle after the last copy
  localparam int TAIL_CYCLES    = 80;
  localparam int WORDS_PER_MODE = 102;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [pubc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pubc_pkg::CFG_W-1:0]     cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [7:0]  in_src_blue;
  logic [7:0]  in_src_green;
  logic [7:0]  in_src_red;
  logic [7:0]  in_src_alpha;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_last_of_run;
  logic        out_end_of_frame;

  pixel_upscale_background_composite i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_src_blue      (in_src_blue),
    .in_src_green     (in_src_green),
    .in_src_red       (in_src_red),
    .in_src_alpha     (in_src_alpha),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // predictor state: register shadows, line store and frame counters
  // ---------------------------------------------------------------------------
  logic [6:0]         scale_reg;
  pubc_pkg::bg_mode_t mode_reg;
  logic [10:0]        canvas_w_reg;
  logic [10:0]        canvas_h_reg;
  logic [10:0]        buf_w_reg;
  logic [10:0]        buf_h_reg;
  pubc_pkg::pixel_t   line_mem [pubc_pkg::MAX_CANVAS_WIDTH_DEF];
  // guards replays of unwritten columns
  logic               line_written [pubc_pkg::MAX_CANVAS_WIDTH_DEF];
  logic [9:0]         col_cnt;
  logic [9:0]         row_cnt;
  logic [5:0]         rep_cnt;

  copy_t    pending_copies[$];   // output words still owed by the block, oldest first
  dir_row_t directed_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int cycle_count;
  int mode_words;

  function automatic int clamp_to(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // rounded composite of one channel over a flat background
  function automatic logic [7:0] over_bg(input logic [7:0] s, input logic [7:0] a,
                                         input logic [7:0] bg);
    int v;
    v = int'(s) * int'(a) + int'(bg) * (int'(pubc_pkg::CH_MAX) - int'(a)) +
        int'(pubc_pkg::ROUND_C);
    return 8'(v / int'(pubc_pkg::CH_MAX));
  endfunction

  // works out the copies of one accepted word and advances the frame counters
  task automatic upscale_word(input op_t op, input pubc_pkg::pixel_t src, input logic typed,
                              input pubc_pkg::pixel_t want);
    int     scale;
    int     width;
    int     height;
    int     c;
    int     r;
    int     k;
    logic   buf_hit;
    logic   row_end;
    logic   pass_end;
    logic   frame_end;
    logic [7:0] bg;
    pubc_pkg::pixel_t px;
    copy_t  cp;
    begin
      scale  = clamp_to(int'(scale_reg), 1, pubc_pkg::MAX_SCALE_DEF);
      width  = clamp_to(int'(canvas_w_reg), 1, pubc_pkg::MAX_CANVAS_WIDTH_DEF);
      height = clamp_to(int'(canvas_h_reg), 1, pubc_pkg::HEIGHT_LIMIT);
      c = int'(col_cnt);
      r = int'(row_cnt);
      if (op == OP_PIXEL) begin
        buf_hit = (c < int'(buf_w_reg)) && (r < int'(buf_h_reg)) && (c < width) &&
                  (r < height);
        bg = (mode_reg == pubc_pkg::BG_WHITE) ? pubc_pkg::CH_MAX : 8'd0;
        if (mode_reg == pubc_pkg::BG_TRANSPARENT) begin
          px = buf_hit ? src : '0;
        end else if (!buf_hit) begin
          px.red   = bg;
          px.green = bg;
          px.blue  = bg;
          px.alpha = pubc_pkg::CH_MAX;
        end else begin
          px.red   = over_bg(src.red, src.alpha, bg);
          px.green = over_bg(src.green, src.alpha, bg);
          px.blue  = over_bg(src.blue, src.alpha, bg);
          px.alpha = pubc_pkg::CH_MAX;
        end
        line_mem[c]     = px;
        line_written[c] = 1'b1;
      end else begin
        px = line_mem[c];
      end
      row_end   = (c + 1 >= width);
      pass_end  = row_end && (int'(rep_cnt) + 1 >= scale);
      frame_end = pass_end && (r + 1 >= height);
      if (typed) px = want;
      for (k = 0; k < scale; k++) begin
        cp.px           = px;
        cp.last_of_run  = (k + 1 == scale);
        cp.end_of_frame = (k + 1 == scale) && frame_end;
        pending_copies.push_back(cp);
      end
      if (row_end) begin
        col_cnt = '0;
        if (pass_end) begin
          rep_cnt = '0;
          row_cnt = frame_end ? 10'd0 : row_cnt + 10'd1;
        end else begin
          rep_cnt = rep_cnt + 6'd1;
        end
      end else begin
        col_cnt = col_cnt + 10'd1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // offers one word, with random idle gaps ahead of it, and predicts it on acceptance
  task automatic send_word(input op_t op, input pubc_pkg::pixel_t src, input logic typed,
                           input pubc_pkg::pixel_t want);
    begin
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid     <= 1'b1;
      in_op        <= op;
      in_src_blue  <= src.blue;
      in_src_green <= src.green;
      in_src_red   <= src.red;
      in_src_alpha <= src.alpha;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      upscale_word(op, src, typed, want);
    end
  endtask

  // sender goes quiet until every owed word has come out, then the block settles
  task automatic quiesce();
    begin
      @(negedge clk);
      in_valid <= 1'b0;
      while (pending_copies.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  // register write; only called while the block is idle
  task automatic write_reg(input pubc_pkg::reg_idx_t idx, input logic [10:0] value);
    begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= value;
      @(negedge clk);
      cfg_we <= 1'b0;
      case (idx)
        pubc_pkg::REG_SCALE_FACTOR:    scale_reg = value[6:0];
        pubc_pkg::REG_BACKGROUND_MODE: mode_reg = pubc_pkg::bg_mode_t'(value[1:0]);
        pubc_pkg::REG_CANVAS_WIDTH:    canvas_w_reg = value;
        pubc_pkg::REG_CANVAS_HEIGHT:   canvas_h_reg = value;
        pubc_pkg::REG_BUFFER_WIDTH:    buf_w_reg = value;
        pubc_pkg::REG_BUFFER_HEIGHT:   buf_h_reg = value;
        default: ;
      endcase
    end
  endtask

  task automatic put_cfg(input pubc_pkg::reg_idx_t idx, input int value);
    dir_row_t row;
    begin
      row.kind  = ROW_CFG;
      row.idx   = idx;
      row.value = 11'(value);
      row.op    = OP_PIXEL;
      row.src   = '0;
      row.typed = 1'b0;
      row.want  = '0;
      directed_rows.push_back(row);
    end
  endtask

  // src and want are packed alpha, blue, green, red from the top byte down
  task automatic put_word(input op_t op, input logic [31:0] src, input logic typed,
                          input logic [31:0] want);
    dir_row_t row;
    begin
      row.kind  = ROW_WORD;
      row.idx   = pubc_pkg::REG_SCALE_FACTOR;
      row.value = '0;
      row.op    = op;
      row.src   = src;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
    end
  endtask

  // new random geometry and mode; scale 64 and wide rows only now and then
  task automatic reconfigure_random();
    int w;
    int h;
    int s;
    begin
      quiesce();
      w = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      case ($urandom_range(9))
        0:       s = $urandom_range(64, 127);   // clamps to 64
        1:       s = 0;                         // clamps to 1
        default: s = $urandom_range(1, 4);
      endcase
      write_reg(pubc_pkg::REG_SCALE_FACTOR, 11'(s));
      write_reg(pubc_pkg::REG_BACKGROUND_MODE, 11'($urandom_range(3)));
      write_reg(pubc_pkg::REG_CANVAS_WIDTH, 11'(w));
      write_reg(pubc_pkg::REG_CANVAS_HEIGHT, 11'(h));
      write_reg(pubc_pkg::REG_BUFFER_WIDTH, 11'($urandom_range(0, w + 1)));
      write_reg(pubc_pkg::REG_BUFFER_HEIGHT, 11'($urandom_range(0, h + 1)));
    end
  endtask

  // mostly well-formed frames: pixels in the source pass, replays after it;
  // one word in ten takes the other op, never a replay of an unwritten column
  task automatic send_random_word();
    op_t              op;
    pubc_pkg::pixel_t src;
    begin
      op = (rep_cnt == 0) ? OP_PIXEL : OP_REPLAY;
      if ($urandom_range(9) == 0) op = (op == OP_PIXEL) ? OP_REPLAY : OP_PIXEL;
      if (op == OP_REPLAY && !line_written[col_cnt]) op = OP_PIXEL;
      src = $urandom;
      case ($urandom_range(7))
        0:       src.alpha = 8'd0;
        1:       src.alpha = pubc_pkg::CH_MAX;
        default: ;
      endcase
      send_word(op, src, 1'b0, '0);
    end
  endtask

  // batches of random words under the current idle profile, each with a full drain inside
  task automatic random_mode();
    int n;
    int k;
    int pause_at;
    begin
      mode_words = 0;
      while (mode_words < WORDS_PER_MODE) begin
        reconfigure_random();
        n = $urandom_range(15, 35);
        pause_at = $urandom_range(0, n - 1);
        for (k = 0; k < n; k++) begin
          if (k == pause_at) quiesce();
          send_random_word();
        end
        mode_words += n;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall decided on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string field, input int want, input int got);
    begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // compare every accepted output word with the oldest owed one
  always @(posedge clk) begin
    copy_t owed;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_copies.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected output word, expected none, actual %0h",
                 $time, {out_alpha, out_blue, out_green, out_red});
      end else begin
        owed = pending_copies.pop_front();
        if (out_red !== owed.px.red) report_mismatch("red", owed.px.red, out_red);
        if (out_green !== owed.px.green) report_mismatch("green", owed.px.green, out_green);
        if (out_blue !== owed.px.blue) report_mismatch("blue", owed.px.blue, out_blue);
        if (out_alpha !== owed.px.alpha) report_mismatch("alpha", owed.px.alpha, out_alpha);
        if (out_last_of_run !== owed.last_of_run)
          report_mismatch("last_of_run", owed.last_of_run, out_last_of_run);
        if (out_end_of_frame !== owed.end_of_frame)
          report_mismatch("end_of_frame", owed.end_of_frame, out_end_of_frame);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid     = 1'b0;
    in_op        = 1'b0;
    in_src_blue  = '0;
    in_src_green = '0;
    in_src_red   = '0;
    in_src_alpha = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    out_stall    = 1'b0;
    rst_n        = 1'b0;
    fail_count   = 0;
    cycle_count  = 0;
    send_idle_pct  = 34;
    recv_stall_pct = 52;

    // register values and counters after reset
    scale_reg    = 7'd1;
    mode_reg     = pubc_pkg::BG_TRANSPARENT;
    canvas_w_reg = 11'd1;
    canvas_h_reg = 11'd1;
    buf_w_reg    = '0;
    buf_h_reg    = '0;
    col_cnt      = '0;
    row_cnt      = '0;
    rep_cnt      = '0;
    for (int i = 0; i < pubc_pkg::MAX_CANVAS_WIDTH_DEF; i++) begin
      line_mem[i]     = '0;
      line_written[i] = 1'b0;
    end

    // directed table; typed rows carry the answer that follows straight from the composite rules
    // empty buffer after reset: transparent mode gives all zeros
    put_word(OP_PIXEL,  32'hFFFFFFFF, 1'b1, 32'h00000000);
    put_cfg(pubc_pkg::REG_BUFFER_WIDTH, 1024);
    put_cfg(pubc_pkg::REG_BUFFER_HEIGHT, 1024);
    // transparent: bgra in, rgba out, alpha kept; then a replay of that column
    put_word(OP_PIXEL,  32'h44112233, 1'b1, 32'h44112233);
    put_word(OP_REPLAY, 32'hA5A5A5A5, 1'b1, 32'h44112233);
    // over black: opaque white stays, fully transparent goes black
    put_cfg(pubc_pkg::REG_BACKGROUND_MODE, pubc_pkg::BG_BLACK);
    put_word(OP_PIXEL,  32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF);
    put_word(OP_PIXEL,  32'h00FFFFFF, 1'b1, 32'hFF000000);
    // over white: fully transparent goes white, opaque black stays
    put_cfg(pubc_pkg::REG_BACKGROUND_MODE, pubc_pkg::BG_WHITE);
    put_word(OP_PIXEL,  32'h00000000, 1'b1, 32'hFFFFFFFF);
    put_word(OP_PIXEL,  32'hFF000000, 1'b1, 32'hFF000000);
    put_word(OP_PIXEL,  32'h804D0AC8, 1'b0, 32'h0);
    // mode 3 behaves as black
    put_cfg(pubc_pkg::REG_BACKGROUND_MODE, pubc_pkg::BG_ALT_BLACK);
    put_word(OP_PIXEL,  32'h804D0AC8, 1'b0, 32'h0);
    // zero-width buffer: every position is outside
    put_cfg(pubc_pkg::REG_BUFFER_WIDTH, 0);
    put_word(OP_PIXEL,  32'h7F3C5A96, 1'b1, 32'hFF000000);
    put_cfg(pubc_pkg::REG_BACKGROUND_MODE, pubc_pkg::BG_TRANSPARENT);
    put_word(OP_PIXEL,  32'h7F3C5A96, 1'b1, 32'h00000000);
    // 2x2 canvas at scale 3, buffer covers only the top-left pixel
    put_cfg(pubc_pkg::REG_SCALE_FACTOR, 3);
    put_cfg(pubc_pkg::REG_CANVAS_WIDTH, 2);
    put_cfg(pubc_pkg::REG_CANVAS_HEIGHT, 2);
    put_cfg(pubc_pkg::REG_BUFFER_WIDTH, 1);
    put_cfg(pubc_pkg::REG_BUFFER_HEIGHT, 1);
    put_cfg(pubc_pkg::REG_BACKGROUND_MODE, pubc_pkg::BG_WHITE);
    put_word(OP_PIXEL,  32'hFF1E140A, 1'b1, 32'hFF1E140A);   // opaque keeps the source
    put_word(OP_PIXEL,  32'h12345678, 1'b1, 32'hFFFFFFFF);   // column outside the buffer
    put_word(OP_REPLAY, 32'h0F0F0F0F, 1'b0, 32'h0);
    put_word(OP_REPLAY, 32'hF0F0F0F0, 1'b0, 32'h0);
    put_word(OP_REPLAY, 32'h0F0F0F0F, 1'b0, 32'h0);
    put_word(OP_REPLAY, 32'hF0F0F0F0, 1'b0, 32'h0);
    put_word(OP_PIXEL,  32'h9ABCDEF0, 1'b1, 32'hFFFFFFFF);   // row outside the buffer
    put_word(OP_REPLAY, 32'h11111111, 1'b0, 32'h0);          // replay in the source pass
    put_word(OP_PIXEL,  32'h55AA55AA, 1'b0, 32'h0);          // pixel in the replay pass
    put_word(OP_REPLAY, 32'h22222222, 1'b0, 32'h0);
    put_word(OP_REPLAY, 32'h33333333, 1'b0, 32'h0);
    put_word(OP_REPLAY, 32'h44444444, 1'b0, 32'h0);          // closes the frame
    // top extremes: scale clamps to 64, canvas to 1024
    put_cfg(pubc_pkg::REG_SCALE_FACTOR, 127);
    put_cfg(pubc_pkg::REG_CANVAS_WIDTH, 2047);
    put_cfg(pubc_pkg::REG_CANVAS_HEIGHT, 2047);
    put_cfg(pubc_pkg::REG_BUFFER_WIDTH, 1024);
    put_cfg(pubc_pkg::REG_BUFFER_HEIGHT, 1024);
    put_cfg(pubc_pkg::REG_BACKGROUND_MODE, pubc_pkg::BG_BLACK);
    put_word(OP_PIXEL,  32'h80FF0001, 1'b0, 32'h0);
    // zero registers clamp to 1; the column counter is already past the new width
    put_cfg(pubc_pkg::REG_SCALE_FACTOR, 0);
    put_cfg(pubc_pkg::REG_CANVAS_WIDTH, 0);
    put_cfg(pubc_pkg::REG_CANVAS_HEIGHT, 0);
    put_word(OP_PIXEL,  32'hC0102030, 1'b0, 32'h0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        quiesce();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_word(directed_rows[i].op, directed_rows[i].src, directed_rows[i].typed,
                  directed_rows[i].want);
      end
    end

    // random part: slow sender and busy receiver, then swapped, then full speed
    random_mode();
    send_idle_pct  = 52;
    recv_stall_pct = 34;
    random_mode();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_mode();

    // drain, then give stray words a chance to show up
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_copies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
